/* sv/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the page frame allocator
// Payload structs, command / status / page-state codes, register map,
// row geometry of the page map memory and the sequencer state type.
// ----------------------------------------------------------------------------
package pfa_pkg;

	// default geometry
	localparam int MAX_PAGES_DEF  = 65536;
	localparam int PAGE_SHIFT_DEF = 12;

	// page map memory row: 16 page states of 2 bits each
	localparam int KIND_W    = 2;
	localparam int ROW_SEL_W = 4;
	localparam int ROW_PAGES = 1 << ROW_SEL_W;
	localparam int ROW_BITS  = ROW_PAGES * KIND_W;

	// wide page number arithmetic (byte address plus length, shifted)
	localparam int PG_W = 33;

	// commands
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_MARK  = 2'd1;
	localparam logic [1:0] CMD_FREE  = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_NOFREE       = 3'd1;
	localparam logic [2:0] ST_MISALIGNED   = 3'd2;
	localparam logic [2:0] ST_ALREADY_FREE = 3'd3;
	localparam logic [2:0] ST_RANGE        = 3'd4;

	// page states
	localparam logic [1:0] KIND_FREE   = 2'd0;
	localparam logic [1:0] KIND_USER   = 2'd1;
	localparam logic [1:0] KIND_SYSTEM = 2'd2;

	// saturation limit of the conflict count
	localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

	// register map (index = paddr[2])
	localparam logic REG_TOTAL = 1'b0;
	localparam logic REG_START = 1'b1;
	localparam int   PADDR_W   = 3;

	localparam logic [16:0] TOTAL_RST = 17'd65536;
	localparam logic [15:0] START_RST = 16'd16384;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] address;
		logic [31:0] length_bytes;
		logic [15:0] page_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [27:0] page_address;
		logic [1:0]  page_kind;
		logic [16:0] conflict_count;
	} rsp_t;

	// register contents handed to the engine
	typedef struct packed {
		logic [16:0] total_pages;
		logic [15:0] search_start_page;
	} cfg_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_READ,
		S_MODIFY,
		S_DONE
	} state_t;

endpackage

/* sv/page_frame_allocator_core.sv */
// ----------------------------------------------------------------------------
// page_frame_allocator_core: first-fit page frame allocator
// Page state map (free / user / system) in one RAM, 16 pages a row; a
// sequencer serves allocate, mark-system, free and state query commands.
// ----------------------------------------------------------------------------
//  channel  | direction | payload        | handshake
//  ---------+-----------+----------------+------------------------------
//  req      | in        | pfa_pkg::req_t | req_valid / req_stall
//  rsp      | out       | pfa_pkg::rsp_t | rsp_valid / rsp_stall
//  config   | in        | 32-bit data    | APB: psel, penable, pwrite
//
//  A command is decoded (PREP); each map row visited is read (READ) and, in MODIFY,
//  written back on change or for mark-system; DONE loads the result register and the
//  next command is taken in IDLE. Free and query visit one row; rejects and empty
//  ranges visit none, so the allocate and mark-system walks set the rate. After
//  reset a clearing pass over the ceil(MAX_PAGES/16) rows (4096 by default)
//  holds req_stall high; config writes are taken. A stalled result holds the rest.
// ----------------------------------------------------------------------------
module page_frame_allocator_core #(
	parameter int MAX_PAGES  = pfa_pkg::MAX_PAGES_DEF,
	parameter int PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pfa_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  pfa_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output pfa_pkg::rsp_t               rsp
);

	localparam int ROWS = (MAX_PAGES + pfa_pkg::ROW_PAGES - 1) / pfa_pkg::ROW_PAGES;
	localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;

	pfa_pkg::cfg_t               cfg;
	logic                        mem_we, mem_re;
	logic [RAW-1:0]              mem_waddr, mem_raddr;
	logic [pfa_pkg::ROW_BITS-1:0] mem_wdata, mem_rdata;

	// configuration registers
	pfa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// command sequencer
	pfa_engine #(
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// page state map
	pfa_ram #(
		.WIDTH (pfa_pkg::ROW_BITS),
		.DEPTH (ROWS)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

/* sv/pfa_ram.sv */
// ----------------------------------------------------------------------------
// pfa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
	parameter  int WIDTH = 32,
	parameter  int DEPTH = 4096,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/pfa_regs.sv */
// ----------------------------------------------------------------------------
// pfa_regs: configuration registers behind an APB-style port
// Page total and allocation search start; writes complete in the access
// phase, reads return the register value, no wait states.
// ----------------------------------------------------------------------------
module pfa_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pfa_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output pfa_pkg::cfg_t              cfg
);

	logic        wr_en;
	logic [16:0] total_q;
	logic [15:0] start_q;

	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= pfa_pkg::TOTAL_RST;
			start_q <= pfa_pkg::START_RST;
		end else if (wr_en) begin
			if (paddr[2] == pfa_pkg::REG_TOTAL) begin
				total_q <= pwdata[16:0];
			end else begin
				start_q <= pwdata[15:0];
			end
		end
	end

	// read mux
	always_comb begin
		case (paddr[2])
			pfa_pkg::REG_TOTAL: prdata = {15'd0, total_q};
			pfa_pkg::REG_START: prdata = {16'd0, start_q};
			default:            prdata = '0;
		endcase
	end

	assign cfg.total_pages       = total_q;
	assign cfg.search_start_page = start_q;

endmodule

/* sv/pfa_engine.sv */
// ----------------------------------------------------------------------------
// pfa_engine: command sequencer of the page frame allocator
// Decodes a command into a row window of the page map, walks the rows with
// read-modify-write (16 page states a row) and holds the result in an
// output register.
// ----------------------------------------------------------------------------
module pfa_engine #(
	parameter  int MAX_PAGES  = pfa_pkg::MAX_PAGES_DEF,
	parameter  int PAGE_SHIFT = pfa_pkg::PAGE_SHIFT_DEF,
	localparam int ROWS       = (MAX_PAGES + pfa_pkg::ROW_PAGES - 1) / pfa_pkg::ROW_PAGES,
	localparam int RAW        = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfa_pkg::cfg_t                 cfg,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  pfa_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output pfa_pkg::rsp_t                 rsp,
	output logic                          mem_we,
	output logic [RAW-1:0]                mem_waddr,
	output logic [pfa_pkg::ROW_BITS-1:0]  mem_wdata,
	output logic                          mem_re,
	output logic [RAW-1:0]                mem_raddr,
	input  logic [pfa_pkg::ROW_BITS-1:0]  mem_rdata
);

	localparam int          PGW      = RAW + pfa_pkg::ROW_SEL_W;
	localparam int          BAW      = PGW + PAGE_SHIFT + 28;
	localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);
	localparam logic [31:0] OFFS_MASK = (32'd1 << PAGE_SHIFT) - 32'd1;
	localparam logic [pfa_pkg::ROW_SEL_W-1:0] ROW_TOP = '1;

	pfa_pkg::state_t state_q, state_d;

	// control
	logic [RAW-1:0] row_q;
	logic           rsp_valid_q;
	logic           slot_free;

	// payload
	pfa_pkg::req_t                   item_q;
	logic [RAW-1:0]                  first_row_q, lim_row_q;
	logic [pfa_pkg::ROW_SEL_W-1:0]   lo_q, hi_q;
	logic [2:0]                      status_q;
	logic [27:0]                     paddr_q;
	logic [1:0]                      kind_q;
	logic [16:0]                     cnt_q;
	pfa_pkg::rsp_t                   rsp_q;

	// decode results
	logic [pfa_pkg::PG_W-1:0] tot, addr_pg, end_pg, start_pg, qry_pg;
	logic [pfa_pkg::PG_W-1:0] prep_first, prep_lim;
	logic                     prep_walk;
	logic [2:0]               prep_status;

	// row modify results
	logic [pfa_pkg::ROW_SEL_W-1:0] lo_eff, hi_eff, pick;
	logic [pfa_pkg::ROW_PAGES-1:0] mask, free_vec, taken_vec;
	logic [pfa_pkg::ROW_BITS-1:0]  mod_row;
	logic                          mod_write, mod_done, found;
	logic [2:0]                    mod_status;
	logic [27:0]                   mod_paddr;
	logic [1:0]                    mod_kind, sel_kind;
	logic [16:0]                   mod_cnt;
	logic [17:0]                   cnt_sum;
	logic [PGW-1:0]                pick_page;
	logic [BAW-1:0]                pick_bytes;

	assign slot_free = !rsp_valid_q || !rsp_stall;

	// command decode: page window and early status
	always_comb begin
		tot = (pfa_pkg::PG_W'(cfg.total_pages) < pfa_pkg::PG_W'(MAX_PAGES)) ?
			pfa_pkg::PG_W'(cfg.total_pages) : pfa_pkg::PG_W'(MAX_PAGES);
		addr_pg  = pfa_pkg::PG_W'(item_q.address) >> PAGE_SHIFT;
		end_pg   = (pfa_pkg::PG_W'(item_q.address) + pfa_pkg::PG_W'(item_q.length_bytes)
			- pfa_pkg::PG_W'(1)) >> PAGE_SHIFT;
		start_pg = pfa_pkg::PG_W'(cfg.search_start_page);
		qry_pg   = pfa_pkg::PG_W'(item_q.page_index);
		prep_walk   = 1'b0;
		prep_status = pfa_pkg::ST_OK;
		prep_first  = qry_pg;
		prep_lim    = qry_pg;
		case (item_q.cmd)
			pfa_pkg::CMD_ALLOC: begin
				prep_status = pfa_pkg::ST_NOFREE;
				prep_first  = start_pg;
				prep_lim    = tot - pfa_pkg::PG_W'(1);
				prep_walk   = start_pg < tot;
			end
			pfa_pkg::CMD_MARK: begin
				prep_first = addr_pg;
				prep_lim   = (end_pg < tot) ? end_pg : tot - pfa_pkg::PG_W'(1);
				if (item_q.length_bytes != 32'd0) begin
					prep_status = (end_pg >= tot) ? pfa_pkg::ST_RANGE : pfa_pkg::ST_OK;
					prep_walk   = addr_pg < tot;
				end
			end
			pfa_pkg::CMD_FREE: begin
				prep_first = addr_pg;
				prep_lim   = addr_pg;
				if ((item_q.address & OFFS_MASK) != 32'd0) begin
					prep_status = pfa_pkg::ST_MISALIGNED;
				end else if (addr_pg >= tot) begin
					prep_status = pfa_pkg::ST_RANGE;
				end else begin
					prep_walk = 1'b1;
				end
			end
			pfa_pkg::CMD_QUERY: begin
				if (qry_pg >= tot) begin
					prep_status = pfa_pkg::ST_RANGE;
				end else begin
					prep_walk = 1'b1;
				end
			end
			default: begin
				prep_walk = 1'b0;
			end
		endcase
	end

	// row read-modify: window mask, first free pick, new row contents
	always_comb begin
		lo_eff = (row_q == first_row_q) ? lo_q : '0;
		hi_eff = (row_q == lim_row_q) ? hi_q : ROW_TOP;
		for (int j = 0; j < pfa_pkg::ROW_PAGES; j++) begin
			mask[j]      = (pfa_pkg::ROW_SEL_W'(j) >= lo_eff) && (pfa_pkg::ROW_SEL_W'(j) <= hi_eff);
			free_vec[j]  = mask[j] && (mem_rdata[j*pfa_pkg::KIND_W +: pfa_pkg::KIND_W]
				== pfa_pkg::KIND_FREE);
			taken_vec[j] = mask[j] && !free_vec[j];
		end
		found = |free_vec;
		pick  = '0;
		for (int j = pfa_pkg::ROW_PAGES - 1; j >= 0; j--) begin
			if (free_vec[j]) begin
				pick = pfa_pkg::ROW_SEL_W'(j);
			end
		end
		pick_page  = {row_q, pick};
		pick_bytes = BAW'({pick_page, {PAGE_SHIFT{1'b0}}});
		sel_kind   = mem_rdata[lo_q*pfa_pkg::KIND_W +: pfa_pkg::KIND_W];
		cnt_sum    = {1'b0, cnt_q} + 18'($countones(taken_vec));

		mod_row    = mem_rdata;
		mod_write  = 1'b0;
		mod_done   = 1'b1;
		mod_status = status_q;
		mod_paddr  = paddr_q;
		mod_kind   = kind_q;
		mod_cnt    = cnt_q;
		case (item_q.cmd)
			pfa_pkg::CMD_ALLOC: begin
				if (found) begin
					mod_row[pick*pfa_pkg::KIND_W +: pfa_pkg::KIND_W] = pfa_pkg::KIND_USER;
					mod_write  = 1'b1;
					mod_status = pfa_pkg::ST_OK;
					mod_paddr  = pick_bytes[27:0];
				end else begin
					mod_done = row_q == lim_row_q;
				end
			end
			pfa_pkg::CMD_MARK: begin
				for (int j = 0; j < pfa_pkg::ROW_PAGES; j++) begin
					if (free_vec[j]) begin
						mod_row[j*pfa_pkg::KIND_W +: pfa_pkg::KIND_W] = pfa_pkg::KIND_SYSTEM;
					end
				end
				mod_write = 1'b1;
				mod_cnt   = (cnt_sum > 18'(pfa_pkg::COUNT_MAX)) ? pfa_pkg::COUNT_MAX : cnt_sum[16:0];
				mod_done  = row_q == lim_row_q;
			end
			pfa_pkg::CMD_FREE: begin
				if (sel_kind == pfa_pkg::KIND_FREE) begin
					mod_status = pfa_pkg::ST_ALREADY_FREE;
				end else begin
					mod_row[lo_q*pfa_pkg::KIND_W +: pfa_pkg::KIND_W] = pfa_pkg::KIND_FREE;
					mod_write = 1'b1;
				end
			end
			pfa_pkg::CMD_QUERY: begin
				mod_kind = sel_kind;
			end
			default: begin
				mod_done = 1'b1;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pfa_pkg::S_CLEAR:  if (row_q == LAST_ROW) state_d = pfa_pkg::S_IDLE;
			pfa_pkg::S_IDLE:   if (req_valid) state_d = pfa_pkg::S_PREP;
			pfa_pkg::S_PREP:   state_d = prep_walk ? pfa_pkg::S_READ : pfa_pkg::S_DONE;
			pfa_pkg::S_READ:   state_d = pfa_pkg::S_MODIFY;
			pfa_pkg::S_MODIFY: state_d = mod_done ? pfa_pkg::S_DONE : pfa_pkg::S_READ;
			pfa_pkg::S_DONE:   if (slot_free) state_d = pfa_pkg::S_IDLE;
			default:           state_d = pfa_pkg::S_IDLE;
		endcase
	end

	// state outputs: memory port and input stall
	always_comb begin
		req_stall = state_q != pfa_pkg::S_IDLE;
		mem_re    = state_q == pfa_pkg::S_READ;
		mem_raddr = row_q;
		mem_waddr = row_q;
		case (state_q)
			pfa_pkg::S_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
			end
			pfa_pkg::S_MODIFY: begin
				mem_we    = mod_write;
				mem_wdata = mod_row;
			end
			default: begin
				mem_we    = 1'b0;
				mem_wdata = mod_row;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfa_pkg::S_CLEAR;
			row_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				pfa_pkg::S_CLEAR:  row_q <= row_q + RAW'(1);
				pfa_pkg::S_PREP:   row_q <= prep_first[PGW-1:pfa_pkg::ROW_SEL_W];
				pfa_pkg::S_MODIFY: if (!mod_done) row_q <= row_q + RAW'(1);
				default:           row_q <= row_q;
			endcase
			if (state_q == pfa_pkg::S_DONE && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			pfa_pkg::S_IDLE: begin
				if (req_valid) item_q <= req;
			end
			pfa_pkg::S_PREP: begin
				first_row_q <= prep_first[PGW-1:pfa_pkg::ROW_SEL_W];
				lim_row_q   <= prep_lim[PGW-1:pfa_pkg::ROW_SEL_W];
				lo_q        <= prep_first[pfa_pkg::ROW_SEL_W-1:0];
				hi_q        <= prep_lim[pfa_pkg::ROW_SEL_W-1:0];
				status_q    <= prep_status;
				paddr_q     <= '0;
				kind_q      <= '0;
				cnt_q       <= '0;
			end
			pfa_pkg::S_MODIFY: begin
				status_q <= mod_status;
				paddr_q  <= mod_paddr;
				kind_q   <= mod_kind;
				cnt_q    <= mod_cnt;
			end
			pfa_pkg::S_DONE: begin
				if (slot_free) begin
					rsp_q.status         <= status_q;
					rsp_q.page_address   <= paddr_q;
					rsp_q.page_kind      <= kind_q;
					rsp_q.conflict_count <= cnt_q;
				end
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* sv/pfa_checker.sv */
// ----------------------------------------------------------------------------
// pfa_checker: port-level assertions for page_frame_allocator_core
// Output hold under stall, one command at a time, and consistency of the
// result fields with the status.
// ----------------------------------------------------------------------------
module pfa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_stall,
	input logic                        rsp_valid,
	input logic                        rsp_stall,
	input pfa_pkg::rsp_t               rsp
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// a command transfer is followed by req_stall high
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("command taken while another is in flight");

	// failed commands return no address and no page state
	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != pfa_pkg::ST_OK |->
			rsp.page_address == 28'd0 && rsp.page_kind == 2'd0)
		else $error("failed result carries address or state");

	// a conflict count, which only mark-system makes, comes with no address or page state
	a_cnt_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.conflict_count != 17'd0 |->
			rsp.page_address == 28'd0 && rsp.page_kind == 2'd0)
		else $error("conflict count mixed with other result fields");

endmodule

bind page_frame_allocator_core pfa_checker u_pfa_checker (.*);
